// ===== hdl/crsf_frame_assembler_defines.svh =====
// Assertion macros shared by the frame assembler modules.
`ifndef CRSF_FRAME_ASSEMBLER_DEFINES_SVH
`define CRSF_FRAME_ASSEMBLER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define CRSF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define CRSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/crsf_pkg.sv =====
// Shared constants, types and register codes of the frame assembler.
`timescale 1ns / 1ps
package crsf_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
	localparam int RAM_AW      = IDX_W + 1;
	localparam int MAX_LEN     = STORE_DEPTH - 4;
	localparam int OUT_DEPTH   = 4;
	localparam int OPTR_W      = $clog2(OUT_DEPTH);
	localparam int OCC_W       = $clog2(OUT_DEPTH + 1);

	typedef enum logic [2:0] {
		REG_ENABLE          = 3'd0,
		REG_ADDRESS_PRIMARY = 3'd1,
		REG_ADDRESS_SYNC    = 3'd2,
		REG_CHANNELS_TYPE   = 3'd3,
		REG_CRC_POLYNOMIAL  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] address_primary;
		logic [7:0] address_sync;
		logic [7:0] channels_type;
		logic [7:0] crc_polynomial;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [RAM_AW-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	// One finished good frame: index of its final byte.
	typedef struct packed {
		logic             valid;
		logic [IDX_W-1:0] last_idx;
	} job_t;

endpackage

// ===== hdl/crsf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module crsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read; read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/crsf_front.sv =====
// Front end: hunts for frame starts, stores bytes, checks length, type and CRC.
`timescale 1ns / 1ps
`include "crsf_frame_assembler_defines.svh"
module crsf_front
	import crsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       push,
	input  logic [7:0] rx_byte,
	input  logic       job_full,
	output ram_wr_t    ram_wr,
	output job_t       job_push
);

	logic [IDX_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] len_q, len_d;
	logic [7:0]       type_q, type_d;
	logic [7:0]       crc_q, crc_d;
	logic             bank_q, bank_d;
	logic             accept;
	logic             is_addr;
	logic             bad_len;
	logic [IDX_W-1:0] cnt_inc;
	logic [7:0]       type_now;
	logic [7:0]       crc_next;

	// Bitwise CRC-8, MSB first
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	assign accept   = push && !job_full;
	assign is_addr  = (rx_byte == cfg.address_primary) || (rx_byte == cfg.address_sync);
	assign bad_len  = (rx_byte == 8'd0) || (rx_byte > 8'(MAX_LEN));
	assign cnt_inc  = count_q + IDX_W'(1);
	assign type_now = (cnt_inc == IDX_W'(3)) ? rx_byte : type_q;
	assign crc_next = crc8_step(crc_q, rx_byte, cfg.crc_polynomial);

	// Classify the incoming byte and advance the frame
	always_comb begin
		count_d  = count_q;
		len_d    = len_q;
		type_d   = type_q;
		crc_d    = crc_q;
		bank_d   = bank_q;
		ram_wr   = '0;
		job_push = '0;
		if (accept) begin
			if (!cfg.enable) begin
				count_d = '0;
				crc_d   = '0;
			end else if (count_q == '0) begin
				if (is_addr) begin
					ram_wr  = '{en: 1'b1, addr: {bank_q, IDX_W'(0)}, data: rx_byte};
					count_d = IDX_W'(1);
				end
			end else if (count_q == IDX_W'(1)) begin
				if (bad_len) begin
					crc_d = '0;
					if (is_addr) begin
						// keep the length byte as a new start
						ram_wr  = '{en: 1'b1, addr: {bank_q, IDX_W'(0)}, data: rx_byte};
						count_d = IDX_W'(1);
					end else begin
						count_d = '0;
					end
				end else begin
					ram_wr  = '{en: 1'b1, addr: {bank_q, IDX_W'(1)}, data: rx_byte};
					len_d   = rx_byte[IDX_W-1:0];
					count_d = IDX_W'(2);
				end
			end else begin
				ram_wr = '{en: 1'b1, addr: {bank_q, count_q}, data: rx_byte};
				if (cnt_inc == IDX_W'(3)) begin
					type_d = rx_byte;
				end
				if (cnt_inc <= len_q + IDX_W'(1)) begin
					crc_d = crc_next;
				end
				if (cnt_inc == len_q + IDX_W'(2)) begin
					// frame complete: hand good frames to the back end
					count_d = '0;
					crc_d   = '0;
					if ((crc_q == rx_byte) && (type_now == cfg.channels_type)) begin
						job_push = '{valid: 1'b1, last_idx: count_q};
						bank_d   = ~bank_q;
					end
				end else begin
					count_d = cnt_inc;
				end
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			crc_q   <= '0;
			bank_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			crc_q   <= crc_d;
			bank_q  <= bank_d;
		end
	end

	// Frame header fields
	always_ff @(posedge clk) begin
		len_q  <= len_d;
		type_q <= type_d;
	end

	`CRSF_ASSERT_NOW(a_count_in_frame, count_q >= IDX_W'(2), count_q <= len_q + IDX_W'(1),
		"front: byte count ran past frame end")
	`CRSF_ASSERT_NOW(a_push_not_full, job_push.valid, !job_full,
		"front: job pushed while both banks busy")

endmodule

// ===== hdl/crsf_jobq.sv =====
// Two-entry queue of finished frames between front and back end.
`timescale 1ns / 1ps
`include "crsf_frame_assembler_defines.svh"
module crsf_jobq
	import crsf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output job_t head
);

	logic [IDX_W-1:0] slot_q [2];
	logic             wp_q;
	logic             rp_q;
	logic [1:0]       cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.last_idx = slot_q[rp_q];

	// Store a new job
	always_ff @(posedge clk) begin
		if (push_job.valid) begin
			slot_q[wp_q] <= push_job.last_idx;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push_job.valid) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push_job.valid) - 2'(pop);
		end
	end

	`CRSF_ASSERT_NOW(a_pop_not_empty, pop, head.valid, "jobq: pop while empty")

endmodule

// ===== hdl/crsf_back.sv =====
// Back end: reads stored frames out of the RAM into the result queue.
`timescale 1ns / 1ps
`include "crsf_frame_assembler_defines.svh"
module crsf_back
	import crsf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  job_t              head,
	output logic              job_pop,
	output logic [RAM_AW-1:0] ram_raddr,
	input  logic [7:0]        ram_rdata,
	input  logic              pop,
	output logic              empty,
	output logic [7:0]        frame_byte,
	output logic              frame_last
);

	logic [IDX_W-1:0]  idx_q;
	logic              bank_q;
	logic              rd_s1;
	logic              last_s1;
	logic              issue;
	logic              is_last;
	logic [8:0]        buf_q [OUT_DEPTH];
	logic [OPTR_W-1:0] wp_q;
	logic [OPTR_W-1:0] rp_q;
	logic [OCC_W-1:0]  occ_q;
	logic              deq;

	// Issue a read when the result queue has room for it
	assign issue     = head.valid && ((occ_q + OCC_W'(rd_s1)) < OCC_W'(OUT_DEPTH));
	assign is_last   = (idx_q == head.last_idx);
	assign job_pop   = issue && is_last;
	assign ram_raddr = {bank_q, idx_q};

	assign empty      = (occ_q == '0);
	assign deq        = pop && !empty;
	assign frame_byte = buf_q[rp_q][8:1];
	assign frame_last = buf_q[rp_q][0];

	// Walk the frame, then flip to the other bank
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			bank_q <= 1'b0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= issue;
			if (issue) begin
				if (is_last) begin
					idx_q  <= '0;
					bank_q <= ~bank_q;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= is_last;
		if (rd_s1) begin
			buf_q[wp_q] <= {ram_rdata, last_s1};
		end
	end

	// Result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			occ_q <= '0;
		end else begin
			if (rd_s1) begin
				wp_q <= wp_q + OPTR_W'(1);
			end
			if (deq) begin
				rp_q <= rp_q + OPTR_W'(1);
			end
			occ_q <= occ_q + OCC_W'(rd_s1) - OCC_W'(deq);
		end
	end

	`CRSF_ASSERT_NOW(a_room_on_return, rd_s1, occ_q < OCC_W'(OUT_DEPTH),
		"back: read data returned into a full result queue")
	`CRSF_ASSERT_NEXT(a_read_returns, issue, rd_s1, "back: issued read did not return")

endmodule

// ===== hdl/crsf_frame_assembler.sv =====
// Top level of the frame assembler: registers, front end, job queue, back end, RAM.
// Readout: after its CRC byte is accepted, a good frame goes through the job queue,
// RAM read register and result queue; bytes follow one per cycle while pop is held.
// Throughput: one received byte per cycle; input stalls (full) only while two
// finished frames fill both RAM banks; readout gives one byte a cycle while pop is held.
// Reset: arst_n clears all control state at once and loads the register defaults;
// the frame RAM keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
module crsf_frame_assembler
	import crsf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] frame_byte,
	output logic       frame_last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cfg_t              cfg_q;
	ram_wr_t           ram_wr;
	job_t              job_push;
	job_t              job_head;
	logic              job_full;
	logic              job_pop;
	logic [RAM_AW-1:0] ram_raddr;
	logic [7:0]        ram_rdata;

	assign cfg_ready = 1'b1;
	assign full      = job_full;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{enable: 1'b1, address_primary: 8'd234, address_sync: 8'd200,
				channels_type: 8'd22, crc_polynomial: 8'd213};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:          cfg_q.enable          <= cfg_data[0];
				REG_ADDRESS_PRIMARY: cfg_q.address_primary <= cfg_data;
				REG_ADDRESS_SYNC:    cfg_q.address_sync    <= cfg_data;
				REG_CHANNELS_TYPE:   cfg_q.channels_type   <= cfg_data;
				REG_CRC_POLYNOMIAL:  cfg_q.crc_polynomial  <= cfg_data;
				default: ;
			endcase
		end
	end

	crsf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.rx_byte  (rx_byte),
		.job_full (job_full),
		.ram_wr   (ram_wr),
		.job_push (job_push)
	);

	crsf_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_job (job_push),
		.pop      (job_pop),
		.full     (job_full),
		.head     (job_head)
	);

	crsf_ram #(
		.WIDTH (8),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	crsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (job_head),
		.job_pop    (job_pop),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.pop        (pop),
		.empty      (empty),
		.frame_byte (frame_byte),
		.frame_last (frame_last)
	);

endmodule
